// ===== hw/rtl/bezier_curve_tessellator_core_macros.svh =====
`ifndef BEZIER_CURVE_TESSELLATOR_CORE_MACROS_SVH
`define BEZIER_CURVE_TESSELLATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BCT_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bct check failed");
`define BCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bct check failed");
`else
`define BCT_ASSERT_IMP(label, clk, rst, ante, cons)
`define BCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/bct_pkg.sv =====
package bct_pkg;

  localparam int COORD_BITS = 16;
  localparam int MAX_STEPS  = 63;
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int PPS_RESET  = 16;

  localparam int T_FRAC = 16;
  localparam int T_W    = T_FRAC + 1;
  localparam logic [T_W-1:0] T_ONE = {1'b1, {T_FRAC{1'b0}}};

  localparam int PT_W    = 3 * COORD_BITS;
  localparam int TDATA_W = ((PT_W + 7) / 8) * 8;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = STEP_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POINTS_PER_SEGMENT = 1'b0,
    REG_QUADRATIC_MODE     = 1'b1
  } cfg_reg_t;

  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [2:0] point_t;

  typedef struct packed {
    point_t [3:0]      pts;
    logic              quad;
    logic [STEP_W-1:0] steps;
  } seg_job_t;

endpackage

// ===== hw/rtl/bct_front.sv =====
module bct_front import bct_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  point_t            cur,
  input  logic              start,
  input  logic              quad,
  input  logic [STEP_W-1:0] steps,
  input  logic              q_full,
  output logic              push,
  output seg_job_t          job
);

  logic [1:0] pic;
  logic [1:0] pic_eff;
  logic       closes;
  logic       take;
  point_t     hist [3];

  assign pic_eff  = start ? 2'd0 : pic;
  assign closes   = quad ? (pic_eff >= 2'd2) : (pic_eff == 2'd3);
  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && closes;

  always_comb begin
    job.pts[0] = hist[0];
    job.pts[1] = hist[1];
    job.pts[2] = quad ? cur : hist[2];
    job.pts[3] = cur;
    job.quad   = quad;
    job.steps  = steps;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pic <= 2'd0;
    end else if (take) begin
      pic <= closes ? 2'd1 : pic_eff + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      if (closes) begin
        hist[0] <= cur;
      end else begin
        hist[pic_eff] <= cur;
      end
    end
  end

endmodule

// ===== hw/rtl/bct_queue.sv =====
`include "bezier_curve_tessellator_core_macros.svh"

module bct_queue import bct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  seg_job_t push_data,
  output logic     full,
  input  logic     pop,
  output seg_job_t pop_data,
  output logic     nonempty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  seg_job_t           slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `BCT_ASSERT_IMP(a_no_overflow, clk, rst, push, !full || pop)
  `BCT_ASSERT_IMP(a_no_underflow, clk, rst, pop, nonempty)

endmodule

// ===== hw/rtl/bct_back.sv =====
`include "bezier_curve_tessellator_core_macros.svh"

module bct_back import bct_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     nonempty,
  input  seg_job_t job_in,
  output logic     pop,
  output logic     out_valid,
  input  logic     out_ready,
  output point_t   out_point,
  output logic     out_last
);

  localparam int MULW_A  = 2 * T_FRAC + 1;
  localparam int WPROD_W = MULW_A + T_W;
  localparam int WT_W    = 3 * T_FRAC + 1;
  localparam int SPLIT   = 24;
  localparam int OPND_W  = WT_W - SPLIT;
  localparam int PROD_W  = OPND_W + 1 + COORD_BITS;
  localparam int ACC_W   = WT_W + COORD_BITS + 2;
  localparam int DIVC_W  = $clog2(T_W);
  localparam logic [DIVC_W-1:0] DIV_LAST   = DIVC_W'(T_W - 1);
  localparam logic [2:0]        WSTEP_LAST = 3'd5;
  localparam logic [3:0]        BLEND_LAST = 4'd8;
  localparam logic [MULW_A-1:0] SQ_ONE     = {1'b1, {(2 * T_FRAC){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_WEIGHT,
    ST_FORM,
    ST_BLEND,
    ST_EMIT
  } state_t;

  state_t              state;
  seg_job_t            job;
  logic [STEP_W-1:0]   steps_eff;
  logic [STEP_W-1:0]   steps_in;
  logic [DIVC_W-1:0]   div_cnt;
  logic [T_W-1:0]      quo;
  logic [STEP_W-1:0]   rem;
  logic [STEP_W-1:0]   frac;
  logic [STEP_W-1:0]   k;
  logic [T_W-1:0]      t;
  logic [T_W-1:0]      u;
  logic [2:0]          wstep;
  logic [MULW_A-1:0]   uu;
  logic [MULW_A-1:0]   tt;
  logic [WT_W-1:0]     w0r;
  logic [WT_W-1:0]     w1r;
  logic [WT_W-1:0]     w2r;
  logic [WT_W-1:0]     w3r;
  logic [WT_W-1:0]     wt [4];
  logic [WT_W-1:0]     wt_next [4];
  logic [3:0]          bstep;
  logic                prod_hi;
  logic signed [PROD_W-1:0] prod [3];
  logic signed [ACC_W-1:0]  acc [3];

  logic                div_done;
  logic [STEP_W:0]     div_trial;
  logic [STEP_W:0]     steps_wide;
  logic                div_ge;
  logic [STEP_W-1:0]   rem_next;
  logic [STEP_W:0]     frac_sum;
  logic                frac_wrap;
  logic [STEP_W-1:0]   frac_next;
  logic [T_W-1:0]      t_inc;
  logic [MULW_A-1:0]   wa;
  logic [T_W-1:0]      wb;
  logic [WPROD_W-1:0]  wprod;
  logic [MULW_A-1:0]   mid_sq;
  logic [WT_W-1:0]     wsel;
  logic [OPND_W-1:0]   opnd;
  coord_t                   lane_c [3];
  logic signed [PROD_W-1:0] mres [3];
  logic signed [ACC_W-1:0]  acc_term [3];

  assign pop = (state == ST_IDLE) && nonempty;

  assign steps_in = (job_in.steps == '0) ? STEP_W'(1) :
                    (job_in.steps > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : job_in.steps;

  assign div_done   = (state == ST_DIV) && (div_cnt == DIV_LAST);
  assign steps_wide = {1'b0, steps_eff};
  assign div_trial  = {rem, (div_cnt == '0)};
  assign div_ge     = (div_trial >= steps_wide);
  assign rem_next   = div_ge ? STEP_W'(div_trial - steps_wide) : STEP_W'(div_trial);

  assign frac_sum  = {1'b0, frac} + {1'b0, rem};
  assign frac_wrap = (frac_sum >= steps_wide);
  assign frac_next = frac_wrap ? STEP_W'(frac_sum - steps_wide) : STEP_W'(frac_sum);
  assign t_inc     = quo + T_W'(frac_wrap);

  always_comb begin
    unique case (wstep)
      3'd0: begin
        wa = MULW_A'(u);
        wb = u;
      end
      3'd1: begin
        wa = MULW_A'(t);
        wb = t;
      end
      3'd2: begin
        wa = uu;
        wb = u;
      end
      3'd3: begin
        wa = uu;
        wb = t;
      end
      3'd4: begin
        wa = tt;
        wb = u;
      end
      default: begin
        wa = tt;
        wb = t;
      end
    endcase
    wprod = WPROD_W'(wa) * WPROD_W'(wb);
  end

  always_comb begin
    mid_sq = SQ_ONE - uu - tt;
    if (job.quad) begin
      wt_next[0] = {uu, {T_FRAC{1'b0}}};
      wt_next[1] = {mid_sq, {T_FRAC{1'b0}}};
      wt_next[2] = {tt, {T_FRAC{1'b0}}};
      wt_next[3] = '0;
    end else begin
      wt_next[0] = w0r;
      wt_next[1] = w1r + {w1r[WT_W-2:0], 1'b0};
      wt_next[2] = w2r + {w2r[WT_W-2:0], 1'b0};
      wt_next[3] = w3r;
    end
  end

  always_comb begin
    wsel = wt[bstep[2:1]];
    opnd = bstep[0] ? wsel[WT_W-1:SPLIT] : OPND_W'(wsel[SPLIT-1:0]);
    for (int a = 0; a < 3; a++) begin
      lane_c[a]   = job.pts[bstep[2:1]][a];
      mres[a]     = $signed({1'b0, opnd}) * lane_c[a];
      acc_term[a] = {{(ACC_W - PROD_W){prod[a][PROD_W-1]}}, prod[a]};
      if (prod_hi) begin
        acc_term[a] = acc_term[a] <<< SPLIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (nonempty) begin
            job       <= job_in;
            steps_eff <= steps_in;
            div_cnt   <= '0;
            quo       <= '0;
            rem       <= '0;
            state     <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem     <= rem_next;
          quo     <= {quo[T_W-2:0], div_ge};
          div_cnt <= div_cnt + 1'b1;
          if (div_done) begin
            k     <= '0;
            t     <= '0;
            u     <= T_ONE;
            frac  <= '0;
            wstep <= '0;
            state <= ST_WEIGHT;
          end
        end
        ST_WEIGHT: begin
          unique case (wstep)
            3'd0:    uu  <= wprod[MULW_A-1:0];
            3'd1:    tt  <= wprod[MULW_A-1:0];
            3'd2:    w0r <= wprod[WT_W-1:0];
            3'd3:    w1r <= wprod[WT_W-1:0];
            3'd4:    w2r <= wprod[WT_W-1:0];
            default: w3r <= wprod[WT_W-1:0];
          endcase
          wstep <= wstep + 1'b1;
          if (wstep == WSTEP_LAST) begin
            state <= ST_FORM;
          end
        end
        ST_FORM: begin
          for (int i = 0; i < 4; i++) begin
            wt[i] <= wt_next[i];
          end
          for (int a = 0; a < 3; a++) begin
            acc[a] <= '0;
          end
          bstep <= '0;
          state <= ST_BLEND;
        end
        ST_BLEND: begin
          for (int a = 0; a < 3; a++) begin
            if (bstep != '0) begin
              acc[a] <= acc[a] + acc_term[a];
            end
            prod[a] <= mres[a];
          end
          prod_hi <= bstep[0];
          bstep   <= bstep + 1'b1;
          if (bstep == BLEND_LAST) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            for (int a = 0; a < 3; a++) begin
              out_point[a] <= acc[a][3 * T_FRAC +: COORD_BITS];
            end
            out_last  <= (k == steps_eff);
            out_valid <= 1'b1;
            if (k == steps_eff) begin
              state <= ST_IDLE;
            end else begin
              k     <= k + 1'b1;
              frac  <= frac_next;
              t     <= t + t_inc;
              u     <= u - t_inc;
              wstep <= '0;
              state <= ST_WEIGHT;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `BCT_ASSERT_IMP(a_frac_below_steps, clk, rst, state == ST_WEIGHT, frac < steps_eff)
  `BCT_ASSERT_IMP(a_last_at_one, clk, rst, state == ST_EMIT && k == steps_eff, t == T_ONE)
  `BCT_ASSERT_NEXT(a_div_to_weight, clk, rst, div_done, state == ST_WEIGHT && k == '0 && t == '0)

endmodule

// ===== hw/rtl/bezier_curve_tessellator_core.sv =====
// Bezier curve tessellator, cubic or quadratic, fixed point.
// Slave stream: one control point per beat, x/y/z in tdata, tuser high starts
// a new curve. Master stream: one curve point per beat, x/y/z in tdata, tlast
// high on the t = 1 point of each segment.
// Config channel: index 0 sets steps per segment N (0 acts as 1), index 1
// selects quadratic segments. Write only while the block is idle.
// A segment closes on the 4th, 7th, ... point of a curve (3rd, 5th, ... in
// quadratic mode) and then yields N + 1 curve points.
// The back end takes a closed segment from the queue only while idle, so one
// segment is worked on at a time; a restoring divide for 65536 / N runs once
// per segment; each curve point then takes 6 weight multiplies on the shared
// multiplier, form, a blend of 8 lane multiply-accumulates, and emit. Control
// points are taken whenever the segment queue is not full, whether or not they
// close a segment. A two-entry segment queue sits between front and back, so
// input keeps flowing while fewer than two closed segments wait.
// Reset clears the point count and the queue; config returns to N = 16, cubic.
// When the receiver stalls, the output register holds the beat and the back
// end waits with the next point computed; the queue then fills and tready drops.
module bezier_curve_tessellator_core import bct_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [TDATA_W-1:0]     s_tdata,   // ctrl_x, ctrl_y, ctrl_z
  input  logic                   s_tuser,   // curve_start
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [TDATA_W-1:0]     m_tdata,   // curve_x, curve_y, curve_z
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [STEP_W-1:0] points_per_segment;
  logic              quadratic_mode;
  point_t            in_point;
  point_t            out_point;
  logic              push;
  logic              pop;
  logic              q_full;
  logic              q_nonempty;
  seg_job_t          push_job;
  seg_job_t          pop_job;

  assign cfg_ready = 1'b1;
  assign in_point  = s_tdata[PT_W-1:0];
  assign m_tdata   = TDATA_W'(out_point);

  always_ff @(posedge clk) begin
    if (rst) begin
      points_per_segment <= STEP_W'(PPS_RESET);
      quadratic_mode     <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POINTS_PER_SEGMENT: points_per_segment <= cfg_data[STEP_W-1:0];
        REG_QUADRATIC_MODE:     quadratic_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cur      (in_point),
    .start    (s_tuser),
    .quad     (quadratic_mode),
    .steps    (points_per_segment),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  bct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_job),
    .nonempty  (q_nonempty)
  );

  bct_back u_back (
    .clk       (clk),
    .rst       (rst),
    .nonempty  (q_nonempty),
    .job_in    (pop_job),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_point (out_point),
    .out_last  (m_tlast)
  );

endmodule
